@@ hw/rtl/toeq_pkg.sv @@
package toeq_pkg;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_CLR  = 2'd3
	} op_t;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned KIND_W  = 4;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OCC_W   = 5;

	// one stored event
	typedef struct packed {
		logic [TIME_W-1:0]  ev_time;
		logic [KIND_W-1:0]  ev_kind;
		logic [VALUE_W-1:0] ev_value;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic enq;   // insert the new event this cycle
		logic deq;   // shift every cell toward the front
	} cell_ctl_t;

endpackage

@@ hw/rtl/toeq_req_if.sv @@
interface toeq_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        func;
	logic [toeq_pkg::TIME_W-1:0]       event_time;
	logic [toeq_pkg::KIND_W-1:0]       event_kind;
	logic [toeq_pkg::VALUE_W-1:0]      event_value;

	modport source (output valid, func, event_time, event_kind, event_value, input ready);
	modport sink   (input valid, func, event_time, event_kind, event_value, output ready);
endinterface

@@ hw/rtl/toeq_rsp_if.sv @@
interface toeq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [toeq_pkg::TIME_W-1:0]       head_time;
	logic [toeq_pkg::KIND_W-1:0]       head_kind;
	logic [toeq_pkg::VALUE_W-1:0]      head_value;
	logic                              was_empty;
	logic                              dropped;
	logic [toeq_pkg::OCC_W-1:0]        occupancy;

	modport source (output valid, head_time, head_kind, head_value, was_empty, dropped,
		occupancy, input ready);
	modport sink   (input valid, head_time, head_kind, head_value, was_empty, dropped,
		occupancy, output ready);
endinterface

@@ hw/rtl/time_ordered_event_queue_top.sv @@
// Time-ordered event queue: a bounded, stable priority queue sorted by trigger time.
//
// Channels: req (sink) carries one operation per beat: func, event_time, event_kind,
// event_value. rsp (source) returns exactly one beat per request: the head event
// (popped or peeked, zeros otherwise), was_empty, dropped and occupancy.
// Ops: enqueue inserts after every entry with equal or earlier time; dequeue pops
// the front; peek reads it; clear empties the queue. A full enqueue is dropped.
//
// Storage is a row of QUEUE_DEPTH cells. Every cell compares its time with the
// incoming one in parallel and either keeps, takes the new event, takes its left
// neighbor (insert) or takes its right neighbor (pop), all in the same cycle.
// Response: registered, valid in the cycle after the request beat is accepted.
// Throughput: one beat per cycle while rsp is not stalled.
// Reset: fill count and response valid clear; slot contents are left as is and
// never read before being written. While rsp is stalled with a pending beat,
// req.ready is low; it rises in the same cycle rsp.ready takes the beat.
module time_ordered_event_queue_top #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	toeq_req_if.sink   req,
	toeq_rsp_if.source rsp
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	toeq_pkg::cell_ctl_t ctl;
	toeq_pkg::entry_t    new_entry;
	toeq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
	logic                cell_later [QUEUE_DEPTH];
	toeq_pkg::op_t       op;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [CW+4:0]       count_ext;
	logic                full;
	logic                empty;
	logic                accept;
	logic                head_sel;
	logic                was_empty_d;
	logic                dropped_d;

	logic                vld_q;
	toeq_pkg::entry_t    head_q;
	logic                was_empty_q;
	logic                dropped_q;
	logic [toeq_pkg::OCC_W-1:0] occ_q;

	assign op        = toeq_pkg::op_t'(req.func);
	assign new_entry = '{ev_time: req.event_time, ev_kind: req.event_kind,
		ev_value: req.event_value};

	// output register frees up when its beat is taken
	assign req.ready = !vld_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	always_comb begin
		ctl         = '0;
		count_d     = count_q;
		head_sel    = 1'b0;
		was_empty_d = 1'b0;
		dropped_d   = 1'b0;
		unique case (op)
			toeq_pkg::OP_ENQ: begin
				dropped_d = full;
				ctl.enq   = accept && !full;
				if (!full) begin
					count_d = count_q + CW'(1);
				end
			end
			toeq_pkg::OP_DEQ: begin
				was_empty_d = empty;
				head_sel    = !empty;
				ctl.deq     = accept && !empty;
				if (!empty) begin
					count_d = count_q - CW'(1);
				end
			end
			toeq_pkg::OP_PEEK: begin
				was_empty_d = empty;
				head_sel    = !empty;
			end
			toeq_pkg::OP_CLR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	assign count_ext = {5'd0, count_d};

	// cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		toeq_pkg::entry_t left_e;
		toeq_pkg::entry_t right_e;
		logic             left_l;
		logic             occ;

		assign occ = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_l = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_l = cell_later[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		toeq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.new_entry   (new_entry),
			.occ         (occ),
			.left_entry  (left_e),
			.left_later  (left_l),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.later       (cell_later[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				vld_q   <= 1'b1;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q      <= head_sel ? cell_entry[0] : '0;
			was_empty_q <= was_empty_d;
			dropped_q   <= dropped_d;
			occ_q       <= count_ext[toeq_pkg::OCC_W-1:0];
		end
	end

	assign rsp.valid      = vld_q;
	assign rsp.head_time  = head_q.ev_time;
	assign rsp.head_kind  = head_q.ev_kind;
	assign rsp.head_value = head_q.ev_value;
	assign rsp.was_empty  = was_empty_q;
	assign rsp.dropped    = dropped_q;
	assign rsp.occupancy  = occ_q;

endmodule

@@ hw/rtl/toeq_cell.sv @@
// One slot of the sorted shift chain.
module toeq_cell (
	input  logic                clk,
	input  toeq_pkg::cell_ctl_t ctl,
	input  toeq_pkg::entry_t    new_entry,
	input  logic                occ,          // slot index below fill count
	input  toeq_pkg::entry_t    left_entry,
	input  logic                left_later,
	input  toeq_pkg::entry_t    right_entry,
	output toeq_pkg::entry_t    entry,
	output logic                later         // slot is empty or strictly later than new
);

	toeq_pkg::entry_t entry_q;

	assign entry = entry_q;
	assign later = !occ || (entry_q.ev_time > new_entry.ev_time);

	always_ff @(posedge clk) begin
		if (ctl.enq && later) begin
			entry_q <= left_later ? left_entry : new_entry;
		end else if (ctl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned DEPTH       = 16;
	localparam int unsigned CYCLE_LIMIT = 500_000;

	// Expected response for one request beat
	typedef struct packed {
		toeq_pkg::entry_t              head;
		logic                          was_empty;
		logic                          dropped;
		logic [toeq_pkg::OCC_W-1:0]    occupancy;
	} head_report_t;

	logic clk;
	logic arst_n;

	toeq_req_if req_ch ();
	toeq_rsp_if rsp_ch ();

	time_ordered_event_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// 4 ns period
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Shadow of the sorted store: slot 0 is the earliest event
	toeq_pkg::entry_t shadow_slot [DEPTH];
	int               shadow_fill;
	head_report_t     head_reports_due[$];

	int           fail_count;
	int unsigned  cycle_count;
	bit           idle_on;       // random gaps on both sides while set
	int           stall_left;

	// Apply one operation to the shadow store and return the response it implies.
	// Ties go behind existing entries, so equal times drain in arrival order.
	function automatic head_report_t apply_to_shadow(toeq_pkg::op_t op,
			logic [toeq_pkg::TIME_W-1:0] t, logic [toeq_pkg::KIND_W-1:0] k,
			logic [toeq_pkg::VALUE_W-1:0] v);
		head_report_t r;
		int pos;
		int i;
		r = '0;
		case (op) inside
			toeq_pkg::OP_ENQ: begin
				if (shadow_fill >= DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					// first slot holding a strictly later time
					pos = shadow_fill;
					for (i = 0; i < shadow_fill; i++) begin
						if (pos == shadow_fill && shadow_slot[i].ev_time > t)
							pos = i;
					end
					for (i = shadow_fill; i > pos; i--)
						shadow_slot[i] = shadow_slot[i-1];
					shadow_slot[pos].ev_time  = t;
					shadow_slot[pos].ev_kind  = k;
					shadow_slot[pos].ev_value = v;
					shadow_fill++;
				end
			end
			toeq_pkg::OP_DEQ, toeq_pkg::OP_PEEK: begin
				if (shadow_fill == 0) begin
					r.was_empty = 1'b1;
				end else begin
					r.head = shadow_slot[0];
					if (op == toeq_pkg::OP_DEQ) begin
						for (i = 1; i < shadow_fill; i++)
							shadow_slot[i-1] = shadow_slot[i];
						shadow_fill--;
					end
				end
			end
			default: begin
				shadow_fill = 0;
			end
		endcase
		r.occupancy = shadow_fill[toeq_pkg::OCC_W-1:0];
		return r;
	endfunction

	// Append one expected report behind the ones already outstanding
	task automatic post_report(head_report_t r);
		head_reports_due.insert(head_reports_due.size(), r);
	endtask

	// Drive one request beat; called and returns at a falling edge.
	// valid stays high after the beat so back-to-back beats need no toggle.
	task automatic send_op(toeq_pkg::op_t op, logic [toeq_pkg::TIME_W-1:0] t,
			logic [toeq_pkg::KIND_W-1:0] k, logic [toeq_pkg::VALUE_W-1:0] v);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.func        = op;
		req_ch.event_time  = t;
		req_ch.event_kind  = k;
		req_ch.event_value = v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		post_report(apply_to_shadow(op, t, k, v));
		@(negedge clk);
	endtask

	// Hold off the sender until every outstanding response has come back
	task automatic wait_reports_drained();
		req_ch.valid = 1'b0;
		while (head_reports_due.size() != 0)
			@(negedge clk);
	endtask

	// Times: full range in 4 of 10 picks, with clusters of equal values to force ties
	function automatic logic [toeq_pkg::TIME_W-1:0] pick_time();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return toeq_pkg::TIME_W'($urandom_range(0, 7)) << 8;
			7:          return '1;
			8:          return '0;
			default:    return 32'hFFFF_FF00 | toeq_pkg::TIME_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Pop, peek and clear on an empty store
	task automatic test_empty_queue();
		send_op(toeq_pkg::OP_PEEK, '1, '1, '1);
		send_op(toeq_pkg::OP_DEQ, '1, '1, '1);
		send_op(toeq_pkg::OP_CLR, '1, '1, '1);
	endtask

	// Fill to capacity with extreme fields and ties, overflow, then pop and clear
	task automatic test_fill_and_overflow();
		int n;
		send_op(toeq_pkg::OP_ENQ, '1, 4'hF, '1);
		send_op(toeq_pkg::OP_ENQ, '0, 4'h0, '0);
		send_op(toeq_pkg::OP_ENQ, 32'h0000_0500, 4'h1, 32'h1111_1111);
		send_op(toeq_pkg::OP_ENQ, 32'h0000_0500, 4'h2, 32'h2222_2222);
		send_op(toeq_pkg::OP_ENQ, 32'h0000_0500, 4'h3, 32'h3333_3333);
		send_op(toeq_pkg::OP_ENQ, '1, 4'h0, '0);           // tie at the maximum time
		send_op(toeq_pkg::OP_ENQ, '0, 4'hF, '1);           // tie at zero
		for (n = 0; n < DEPTH - 7; n++)
			send_op(toeq_pkg::OP_ENQ, $urandom, 4'($urandom_range(0, 15)), $urandom);
		send_op(toeq_pkg::OP_ENQ, 32'h0000_0100, 4'hA, 32'hDEAD_BEEF);   // refused, full
		send_op(toeq_pkg::OP_PEEK, '0, '0, '0);
		send_op(toeq_pkg::OP_DEQ, '0, '0, '0);
		send_op(toeq_pkg::OP_DEQ, '0, '0, '0);
		send_op(toeq_pkg::OP_CLR, '0, '0, '0);
		send_op(toeq_pkg::OP_DEQ, '0, '0, '0);
	endtask

	// Random traffic in phases that push the store toward full, toward empty,
	// or hold it mid-level; clear stays rare so the deep states are reached.
	task automatic random_ops(int count);
		int            n;
		int            phase;
		int            roll;
		int            enq_pct;
		int            deq_pct;
		toeq_pkg::op_t op;
		phase = 0;
		for (n = 0; n < count; n++) begin
			if (n % 32 == 0)
				phase = $urandom_range(0, 2);
			case (phase)
				0:       begin enq_pct = 75; deq_pct = 15; end
				1:       begin enq_pct = 20; deq_pct = 65; end
				default: begin enq_pct = 45; deq_pct = 40; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < enq_pct)
				op = toeq_pkg::OP_ENQ;
			else if (roll < enq_pct + deq_pct)
				op = toeq_pkg::OP_DEQ;
			else if (roll < 98)
				op = toeq_pkg::OP_PEEK;
			else
				op = toeq_pkg::OP_CLR;
			send_op(op, pick_time(), 4'($urandom_range(0, 15)), $urandom);
		end
	endtask

	task automatic test_random_with_gaps();
		idle_on = 1'b1;
		random_ops(1700);
	endtask

	// Full-rate stretch: no gaps on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		random_ops(300);
	endtask

	// Response side: random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 9);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Compare every response beat against the oldest expected report
	always @(posedge clk) begin
		head_report_t due;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (head_reports_due.size() == 0) begin
				$error("response beat with nothing outstanding");
				fail_count++;
			end else begin
				due = head_reports_due.pop_front();
				if (rsp_ch.head_time !== due.head.ev_time) begin
					$error("head_time: expected %h, actual %h", due.head.ev_time,
						rsp_ch.head_time);
					fail_count++;
				end
				if (rsp_ch.head_kind !== due.head.ev_kind) begin
					$error("head_kind: expected %h, actual %h", due.head.ev_kind,
						rsp_ch.head_kind);
					fail_count++;
				end
				if (rsp_ch.head_value !== due.head.ev_value) begin
					$error("head_value: expected %h, actual %h", due.head.ev_value,
						rsp_ch.head_value);
					fail_count++;
				end
				if (rsp_ch.was_empty !== due.was_empty) begin
					$error("was_empty: expected %b, actual %b", due.was_empty,
						rsp_ch.was_empty);
					fail_count++;
				end
				if (rsp_ch.dropped !== due.dropped) begin
					$error("dropped: expected %b, actual %b", due.dropped, rsp_ch.dropped);
					fail_count++;
				end
				if (rsp_ch.occupancy !== due.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", due.occupancy,
						rsp_ch.occupancy);
					fail_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.func        = toeq_pkg::OP_ENQ;
		req_ch.event_time  = '0;
		req_ch.event_kind  = '0;
		req_ch.event_value = '0;
		rsp_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		idle_on            = 1'b1;
		stall_left         = 0;
		shadow_fill        = 0;
		fail_count         = 0;
		cycle_count        = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_fill_and_overflow();
		// sender holds off here until the store has answered everything
		wait_reports_drained();
		test_random_with_gaps();
		test_back_to_back();

		wait_reports_drained();
		// wait out any stray beat before the verdict
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/toeq_pkg.sv
hw/rtl/toeq_req_if.sv
hw/rtl/toeq_rsp_if.sv
hw/rtl/toeq_cell.sv
hw/rtl/time_ordered_event_queue_top.sv
bench/tb_top.sv
